// ===== src/shell_argument_tokenizer_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SHELL_ARGUMENT_TOKENIZER_MACROS_SVH
`define SHELL_ARGUMENT_TOKENIZER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SAT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== src/sat_pkg.sv =====
// Types and constants of the shell argument tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 4;
   localparam int TOTAL_WIDTH         = 16;

   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_END_ARG   = 2'd1,
      KIND_END_INPUT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      QM_NONE   = 2'd0,
      QM_SINGLE = 2'd1,
      QM_DOUBLE = 2'd2
   } quote_type;

endpackage

`default_nettype wire

// ===== src/sat_req_if.sv =====
// Input channel of the tokenizer: one command-line byte per word.
`timescale 1ns / 1ps
`default_nettype none

interface sat_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source  (output valid, output in_byte, output in_last, input ready);
   modport sink    (input valid, input in_byte, input in_last, output ready);
   modport monitor (input valid, input in_byte, input in_last, input ready);
endinterface

`default_nettype wire

// ===== src/sat_rsp_if.sv =====
// Result channel of the tokenizer: argument bytes and markers.
`timescale 1ns / 1ps
`default_nettype none

interface sat_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  out_kind;
   logic [15:0] total_args;
   logic        out_last;

   modport source  (output valid, output out_byte, output out_kind, output total_args,
                    output out_last, input ready);
   modport sink    (input valid, input out_byte, input out_kind, input total_args,
                    input out_last, output ready);
   modport monitor (input valid, input out_byte, input out_kind, input total_args,
                    input out_last, input ready);
endinterface

`default_nettype wire

// ===== src/shell_argument_tokenizer.sv =====
// Top level: shell word splitting of a byte stream into argument words.
//
//   channel   direction  word
//   req_if    in         in_byte, in_last
//   rsp_if    out        out_byte, out_kind, total_args, out_last
//
// A byte is decoded in the cycle it is taken; its 0 to 4 results sit in a
// four-slot result register and leave one per cycle while the output is ready.
// A byte that causes at most one result lets a byte be taken every cycle while the
// output is ready; a byte with more results holds off the input while the slots drain.
// Reset is synchronous and clears the quote state, the count and empties the slots.
// A stalled result stage holds its word and holds off the input.
`timescale 1ns / 1ps
`default_nettype none

module shell_argument_tokenizer
   import sat_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   sat_req_if.sink   req_if,
   sat_rsp_if.source rsp_if
);

   logic                   in_arg_ff, in_arg_in;
   quote_type              quote_ff, quote_in;
   logic                   esc_ff, esc_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [7:0]             slot_byte_ff [MAX_RESULTS];
   kind_type               slot_kind_ff [MAX_RESULTS];
   logic [7:0]             slot_byte_in [MAX_RESULTS];
   kind_type               slot_kind_in [MAX_RESULTS];
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [2:0]             rem_ff, rem_in;
   logic [1:0]             head_ff;

   logic                   req_ready;
   logic                   req_take;
   logic                   rsp_take;
   logic                   is_ws;
   logic [31:0]            count_wide;

   assign req_ready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_if.ready);
   assign req_take  = req_if.valid && req_ready;
   assign rsp_take  = rsp_if.valid && rsp_if.ready;

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = (rem_ff != 3'd0);
   assign rsp_if.out_byte   = slot_byte_ff[head_ff];
   assign rsp_if.out_kind   = slot_kind_ff[head_ff];
   assign rsp_if.total_args = total_ff;
   assign rsp_if.out_last   = (rem_ff == 3'd1);

   assign is_ws = (req_if.in_byte == CHAR_SPACE) ||
                  ((req_if.in_byte >= CHAR_TAB) && (req_if.in_byte <= CHAR_CR));

   assign count_wide = 32'(count_in);
   assign total_in   = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];

   always_comb begin
      logic [2:0] n;
      logic [7:0] b;
      n         = 3'd0;
      b         = req_if.in_byte;
      in_arg_in = in_arg_ff;
      quote_in  = quote_ff;
      esc_in    = 1'b0;
      count_in  = count_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_byte_in[i] = 8'd0;
         slot_kind_in[i] = KIND_BYTE;
      end

      if (esc_ff) begin
         if (b != CHAR_NEWLINE) begin
            if ((quote_ff != QM_DOUBLE) || (b == CHAR_DQUOTE) || (b == CHAR_BACKSLASH)) begin
               slot_byte_in[n[1:0]] = b;
               n = n + 3'd1;
            end else begin
               slot_byte_in[n[1:0]] = CHAR_BACKSLASH;
               n = n + 3'd1;
               slot_byte_in[n[1:0]] = b;
               n = n + 3'd1;
            end
         end
      end else if (!(!in_arg_ff && is_ws)) begin
         if (!in_arg_ff) begin
            in_arg_in = 1'b1;
            if (count_ff != '1) begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         case (quote_ff)
            QM_SINGLE: begin
               if (b == CHAR_SQUOTE) begin
                  quote_in = QM_NONE;
               end else begin
                  slot_byte_in[n[1:0]] = b;
                  n = n + 3'd1;
               end
            end
            QM_DOUBLE: begin
               if (b == CHAR_DQUOTE) begin
                  quote_in = QM_NONE;
               end else if ((b == CHAR_BACKSLASH) && !req_if.in_last) begin
                  esc_in = 1'b1;
               end else begin
                  slot_byte_in[n[1:0]] = b;
                  n = n + 3'd1;
               end
            end
            default: begin
               if (is_ws) begin
                  slot_kind_in[n[1:0]] = KIND_END_ARG;
                  n = n + 3'd1;
                  in_arg_in = 1'b0;
               end else if (b == CHAR_DQUOTE) begin
                  quote_in = QM_DOUBLE;
               end else if (b == CHAR_SQUOTE) begin
                  quote_in = QM_SINGLE;
               end else if ((b == CHAR_BACKSLASH) && !req_if.in_last) begin
                  esc_in = 1'b1;
               end else begin
                  slot_byte_in[n[1:0]] = b;
                  n = n + 3'd1;
               end
            end
         endcase
      end

      if (req_if.in_last) begin
         if (in_arg_in) begin
            slot_kind_in[n[1:0]] = KIND_END_ARG;
            n = n + 3'd1;
         end
         slot_kind_in[n[1:0]] = KIND_END_INPUT;
         n = n + 3'd1;
      end
      rem_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_arg_ff <= 1'b0;
         quote_ff  <= QM_NONE;
         esc_ff    <= 1'b0;
         count_ff  <= '0;
         rem_ff    <= 3'd0;
         head_ff   <= 2'd0;
      end else if (req_take) begin
         rem_ff  <= rem_in;
         head_ff <= 2'd0;
         if (req_if.in_last) begin
            in_arg_ff <= 1'b0;
            quote_ff  <= QM_NONE;
            esc_ff    <= 1'b0;
            count_ff  <= '0;
         end else begin
            in_arg_ff <= in_arg_in;
            quote_ff  <= quote_in;
            esc_ff    <= esc_in;
            count_ff  <= count_in;
         end
      end else if (rsp_take) begin
         rem_ff  <= rem_ff - 3'd1;
         head_ff <= head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         slot_byte_ff <= slot_byte_in;
         slot_kind_ff <= slot_kind_in;
         total_ff     <= total_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/sat_checker.sv =====
// Port checker of the tokenizer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "shell_argument_tokenizer_macros.svh"

module sat_checker
   import sat_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  wire [7:0]             rsp_byte,
   input  wire [1:0]             rsp_kind,
   input  wire [TOTAL_WIDTH-1:0] rsp_total,
   input  wire                   rsp_last
);

   logic [TOTAL_WIDTH+10:0] rsp_word;
   logic                    held;
   logic                    marker;
   logic                    input_end;

   assign rsp_word  = {rsp_byte, rsp_kind, rsp_total, rsp_last};
   assign held      = rsp_valid && !rsp_ready;
   assign marker    = rsp_valid && (rsp_kind != KIND_BYTE);
   assign input_end = rsp_valid && (rsp_kind == KIND_END_INPUT);

   `SAT_ASSERT(a_rsp_hold, held |=> rsp_valid && $stable(rsp_word), "stalled result word changed")
   `SAT_ASSERT(a_kind_code, rsp_valid |-> rsp_kind <= KIND_END_INPUT, "result kind out of range")
   `SAT_ASSERT(a_marker_zero, marker |-> rsp_byte == 8'd0, "marker word carries a byte")
   `SAT_ASSERT(a_end_is_last, input_end |-> rsp_last, "end of input not last of its byte")
   `SAT_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind shell_argument_tokenizer sat_checker u_sat_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_byte  (rsp_if.out_byte),
   .rsp_kind  (rsp_if.out_kind),
   .rsp_total (rsp_if.total_args),
   .rsp_last  (rsp_if.out_last)
);

`default_nettype wire

// ===== sim/shell_argument_tokenizer_test.sv =====
// Self-checking testbench of the shell argument tokenizer: random command lines vs. a predictor.
`timescale 1ns / 1ps

module shell_argument_tokenizer_test;
   import sat_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 300;

   typedef struct packed {
      logic [7:0] chr;
      logic       fin;
      logic       settle;
   } line_char_type;

   typedef struct packed {
      logic [7:0]             chr;
      kind_type               kind;
      logic [TOTAL_WIDTH-1:0] count;
      logic                   fin;
   } token_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sat_req_if req_if ();
   sat_rsp_if rsp_if ();

   shell_argument_tokenizer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   line_char_type  line_chars[$];
   token_word_type token_words[$];
   line_char_type  next_char;

   // predictor state
   logic                   open_arg;
   quote_type              quote_state;
   logic                   escape_wait;
   logic [TOTAL_WIDTH-1:0] arg_total;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   cycles = 0;
   int   errors = 0;
   int   bytes_taken = 0;
   int   words_checked = 0;
   int   lines_closed = 0;
   int   args_closed = 0;
   int   tx_gap = 0;
   int   rx_gap = 0;
   int   rx_hold = 0;
   bit   tx_calm = 1'b0;
   bit   rx_calm = 1'b0;
   bit   hold_done = 1'b0;

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch at word %0d: %s got %0h expected %0h", words_checked, field, got,
               want);
      errors++;
   endtask

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic [7:0] blank_char();
      return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : 8'($urandom_range(9, 13));
   endfunction

   task automatic clear_split();
      open_arg = 1'b0;
      quote_state = QM_NONE;
      escape_wait = 1'b0;
      arg_total = '0;
   endtask

   task automatic put_token(input logic [7:0] c, input kind_type k);
      token_word_type w;
      w.chr = (k == KIND_BYTE) ? c : 8'h00;
      w.kind = k;
      w.count = arg_total;
      w.fin = 1'b0;
      token_words.push_back(w);
   endtask

   task automatic split_char(input logic [7:0] c, input logic fin);
      int             base;
      token_word_type w;
      base = token_words.size();
      if (escape_wait) begin
         escape_wait = 1'b0;
         if (c != CHAR_NEWLINE) begin
            if (quote_state != QM_DOUBLE || c == CHAR_DQUOTE || c == CHAR_BACKSLASH) begin
               put_token(c, KIND_BYTE);
            end else begin
               put_token(CHAR_BACKSLASH, KIND_BYTE);
               put_token(c, KIND_BYTE);
            end
         end
      end else if (!open_arg && is_blank(c)) begin
      end else begin
         if (!open_arg) begin
            open_arg = 1'b1;
            if (arg_total != {TOTAL_WIDTH{1'b1}}) arg_total++;
         end
         case (quote_state)
            QM_SINGLE: begin
               if (c == CHAR_SQUOTE) quote_state = QM_NONE;
               else put_token(c, KIND_BYTE);
            end
            QM_DOUBLE: begin
               if (c == CHAR_DQUOTE) quote_state = QM_NONE;
               else if (c == CHAR_BACKSLASH && !fin) escape_wait = 1'b1;
               else put_token(c, KIND_BYTE);
            end
            default: begin
               if (is_blank(c)) begin
                  put_token(8'h00, KIND_END_ARG);
                  open_arg = 1'b0;
               end else if (c == CHAR_DQUOTE) begin
                  quote_state = QM_DOUBLE;
               end else if (c == CHAR_SQUOTE) begin
                  quote_state = QM_SINGLE;
               end else if (c == CHAR_BACKSLASH && !fin) begin
                  escape_wait = 1'b1;
               end else begin
                  put_token(c, KIND_BYTE);
               end
            end
         endcase
      end
      if (fin) begin
         if (open_arg) put_token(8'h00, KIND_END_ARG);
         put_token(8'h00, KIND_END_INPUT);
         clear_split();
      end
      if (token_words.size() > base) begin
         w = token_words.pop_back();
         w.fin = 1'b1;
         token_words.push_back(w);
      end
   endtask

   task automatic check_word();
      token_word_type want;
      if (token_words.size() == 0) begin
         report_mismatch("word with none pending, kind", 16'(rsp_if.out_kind), 16'h0);
         return;
      end
      want = token_words.pop_front();
      if (rsp_if.out_byte !== want.chr)
         report_mismatch("out_byte", 16'(rsp_if.out_byte), 16'(want.chr));
      if (rsp_if.out_kind !== want.kind)
         report_mismatch("out_kind", 16'(rsp_if.out_kind), 16'(want.kind));
      if (rsp_if.total_args !== want.count)
         report_mismatch("total_args", rsp_if.total_args, want.count);
      if (rsp_if.out_last !== want.fin)
         report_mismatch("out_last", 16'(rsp_if.out_last), 16'(want.fin));
      if (want.kind == KIND_END_ARG) args_closed++;
      if (want.kind == KIND_END_INPUT) lines_closed++;
   endtask

   always @(posedge clock) begin
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
         end
         if (req_if.valid && req_if.ready) begin
            req_fire = 1'b1;
            bytes_taken++;
            split_char(req_if.in_byte, req_if.in_last);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_fire = 1'b1;
            check_word();
            words_checked++;
         end
      end
   end

   // sender: hold until taken, then idle for the drawn gap; a settle byte waits for all results
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_fire) begin
      end else if (tx_gap > 0) begin
         req_if.valid <= 1'b0;
         tx_gap--;
      end else if (line_chars.size() != 0 &&
                   !(line_chars[0].settle && token_words.size() != 0)) begin
         next_char = line_chars.pop_front();
         req_if.in_byte <= next_char.chr;
         req_if.in_last <= next_char.fin;
         req_if.valid <= 1'b1;
         if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
         tx_gap = tx_calm ? 0 : $urandom_range(0, 14);
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // receiver: random stalls, plus one long hold-off to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            rx_gap = rx_calm ? 0 : $urandom_range(0, 14);
            if (!hold_done && words_checked >= 80) begin
               rx_hold = 150;
               hold_done = 1'b1;
            end
         end
         if (rx_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rx_hold--;
         end else if (rx_gap > 0) begin
            rsp_if.ready <= 1'b0;
            rx_gap--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic queue_char(input logic [7:0] c, input logic fin, input logic settle);
      line_char_type e;
      e.chr = c;
      e.fin = fin;
      e.settle = settle;
      line_chars.push_back(e);
   endtask

   task automatic queue_text(input string s, input logic close);
      int k;
      for (k = 0; k < s.len(); k++) queue_char(s[k], close && k == s.len() - 1, 1'b0);
   endtask

   task automatic queue_line(input bit noise, input bit settle);
      logic [7:0] text[$];
      logic [7:0] c;
      int         segs;
      int         len;
      int         k;
      int         j;
      if (noise) begin
         len = $urandom_range(1, 8);
         for (k = 0; k < len; k++) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         segs = $urandom_range(1, 6);
         for (k = 0; k < segs; k++) begin
            case ($urandom_range(0, 5))
               0: begin
                  len = $urandom_range(1, 4);
                  for (j = 0; j < len; j++) text.push_back(8'($urandom_range(97, 122)));
               end
               1: begin
                  len = $urandom_range(1, 2);
                  for (j = 0; j < len; j++) text.push_back(blank_char());
               end
               2: begin
                  text.push_back(CHAR_SQUOTE);
                  len = $urandom_range(0, 3);
                  for (j = 0; j < len; j++) begin
                     c = 8'($urandom_range(0, 255));
                     text.push_back(c == CHAR_SQUOTE ? CHAR_BACKSLASH : c);
                  end
                  if ($urandom_range(0, 7) != 0) text.push_back(CHAR_SQUOTE);
               end
               3: begin
                  text.push_back(CHAR_DQUOTE);
                  len = $urandom_range(0, 3);
                  for (j = 0; j < len; j++) begin
                     case ($urandom_range(0, 3))
                        0: begin
                           text.push_back(CHAR_BACKSLASH);
                           text.push_back(CHAR_DQUOTE);
                        end
                        1: begin
                           text.push_back(CHAR_BACKSLASH);
                           text.push_back(CHAR_BACKSLASH);
                        end
                        2: begin
                           text.push_back(CHAR_BACKSLASH);
                           text.push_back(($urandom_range(0, 1) != 0) ? CHAR_NEWLINE :
                                          8'($urandom_range(97, 122)));
                        end
                        default: begin
                           c = 8'($urandom_range(0, 255));
                           text.push_back(c == CHAR_DQUOTE ? CHAR_SPACE : c);
                        end
                     endcase
                  end
                  if ($urandom_range(0, 7) != 0) text.push_back(CHAR_DQUOTE);
               end
               4: begin
                  text.push_back(CHAR_BACKSLASH);
                  text.push_back(($urandom_range(0, 3) == 0) ? CHAR_NEWLINE :
                                 8'($urandom_range(0, 255)));
               end
               default: text.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      for (k = 0; k < text.size(); k++)
         queue_char(text[k], k == text.size() - 1, settle && k == 0);
   endtask

   initial begin
      int queued;
      int lines;
      req_if.valid = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.in_last = 1'b0;
      rsp_if.ready = 1'b0;
      clear_split();

      // leading blank, empty quoted word, lone line continuation, extreme bytes
      queue_text("\t'' \\\n ", 1'b0);
      queue_char(8'hFF, 1'b0, 1'b0);
      queue_char(8'h00, 1'b1, 1'b0);
      // escapes in double quotes, left unterminated, ending on a continuation
      queue_text("\"\\\"\\\\\\q\\\n", 1'b1);
      queue_text("a\\ b\\", 1'b1);
      queue_text("'x \\'y", 1'b1);
      queue_text("\r", 1'b1);
      queue_text("\"\\", 1'b1);

      queued = 0;
      lines = 0;
      while (queued < RANDOM_BYTES) begin
         k_size: begin
            int before_size;
            before_size = line_chars.size();
            queue_line($urandom_range(0, 5) == 0, lines == 25 || lines == 60);
            queued += line_chars.size() - before_size;
         end
         lines++;
      end

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      while (line_chars.size() != 0 || req_if.valid) @(posedge clock);
      while (token_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run covered %0d bytes in %0d command lines, %0d arguments closed",
               bytes_taken, lines_closed, args_closed);
      $display("%0d result words checked, %0d mismatches", words_checked, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
